@@ hw/rtl/cple_pkg.sv @@
// Package for the cone peak landscape evaluator.
// Holds widths, codes, FSM state type and pipeline stage structs.
// No dependencies.
package cple_pkg;

  localparam int MAX_PEAKS_DEF = 64;

  localparam int COORD_W = 24;   // Q16.8 coordinates and radii
  localparam int HGT_W   = 16;   // Q4.12 heights
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 7;    // peak_count register
  localparam int SQ_W    = 2 * COORD_W;        // one square
  localparam int RAD_W   = 2 * COORD_W + 2;    // sum of squares, padded to even
  localparam int SQ_STEPS = RAD_W / 2;         // one root bit per stage
  localparam int ROOT_W  = SQ_STEPS;
  localparam int REM_W   = ROOT_W + 3;
  localparam int NUM_W   = COORD_W + HGT_W;    // run * height step
  localparam int DIV_STEPS = NUM_W;            // one quotient bit per stage

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  // Which part of the peak profile the point falls in.
  typedef enum logic [1:0] {
    SEG_NONE,
    SEG_UP,      // inner cone, top at or above inner height
    SEG_DOWN,    // inner cone, top below inner height
    SEG_OUTER
  } seg_t;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [HGT_W-1:0]   top;
    logic [COORD_W-1:0] r1;
    logic [HGT_W-1:0]   h1;
    logic [COORD_W-1:0] r2;
  } peak_entry_t;

  typedef struct packed {
    logic [HGT_W-1:0]   top;
    logic [COORD_W-1:0] r1;
    logic [HGT_W-1:0]   h1;
    logic [COORD_W-1:0] r2;
  } pk_t;

  typedef struct packed {
    logic               vld;
    logic               last;
    logic [RAD_W-1:0]   rad;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    pk_t                pk;
  } sq_t;

  typedef struct packed {
    logic               vld;
    logic               last;
    seg_t               seg;
    logic [COORD_W-1:0] a;
    logic [HGT_W-1:0]   b;
    logic [COORD_W-1:0] den;
    logic [HGT_W-1:0]   h1;
  } cls_t;

  typedef struct packed {
    logic               vld;
    logic               last;
    seg_t               seg;
    logic [NUM_W-1:0]   dvd;
    logic [COORD_W-1:0] rem;
    logic [HGT_W-1:0]   quo;
    logic [COORD_W-1:0] den;
    logic [HGT_W-1:0]   h1;
  } dv_t;

endpackage

@@ hw/rtl/cone_peak_landscape_eval.sv @@
// Cone peak landscape evaluator, top level.
// Peak table, per-peak pipelined datapath (square, root, divide) and max reduce.
// Depends on cple_pkg.
//
// Queries: a query with N > 0 active peaks walks the table, one peak read per
//   cycle, and each peak passes through the 25-stage root and 40-stage divider;
//   the result is returned once the last peak drains. N = 0 returns zero
//   directly. No new transaction is taken until the result has been loaded
//   into the output register; a write is taken in the idle state.
// Reset: rst_n synchronous active low clears FSM, valid bits and peak_count;
//   the peak table is not cleared and must be written before it is queried.
module cone_peak_landscape_eval
  import cple_pkg::*;
#(
  parameter int MAX_PEAKS = MAX_PEAKS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, low bit up: slot[6], point_x[24], point_y[24], top_height[16],
  //   inner_radius[24], inner_edge_height[16], outer_radius[24], 2 zero bits
  input  logic [135:0] in_tdata,
  input  logic         in_tuser,   // func: 0 write slot, 1 query
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata: fitness[16]
  output logic [15:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_wr_en,
  input  logic [6:0]   cfg_wr_data  // peak_count
);

  localparam int AW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int CW = $clog2(MAX_PEAKS + 1);

  // ---------------- input unpack ----------------
  logic [SLOT_W-1:0]  in_slot;
  logic [COORD_W-1:0] in_x, in_y, in_r1, in_r2;
  logic [HGT_W-1:0]   in_top, in_h1;
  assign in_slot = in_tdata[5:0];
  assign in_x    = in_tdata[29:6];
  assign in_y    = in_tdata[53:30];
  assign in_top  = in_tdata[69:54];
  assign in_r1   = in_tdata[93:70];
  assign in_h1   = in_tdata[109:94];
  assign in_r2   = in_tdata[133:110];

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // ---------------- config ----------------
  logic [CNT_W-1:0] peak_count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) peak_count_r <= '0;
    else if (cfg_wr_en) peak_count_r <= cfg_wr_data;
  end

  logic [CW-1:0] n_eff;
  assign n_eff = (int'(peak_count_r) > MAX_PEAKS) ? CW'(MAX_PEAKS) : CW'(peak_count_r);

  // ---------------- peak table ----------------
  peak_entry_t mem [0:MAX_PEAKS-1];
  peak_entry_t rd_ent_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  assign wr_addr = AW'(in_slot);

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == FUNC_WRITE && int'(in_slot) < MAX_PEAKS) begin
      mem[wr_addr] <= '{cx: in_x, cy: in_y, top: in_top, r1: in_r1, h1: in_h1, r2: in_r2};
    end
    rd_ent_r <= mem[rd_addr];
  end

  // ---------------- control FSM ----------------
  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, n_r;
  logic [COORD_W-1:0] qx_r, qy_r;
  logic [HGT_W-1:0] best_r, best_nxt;
  logic [15:0] out_data_r;
  logic out_valid_r;
  logic issue_v, issue_last, out_load, fin_v, fin_last;

  assign rd_addr    = cnt_r[AW-1:0];
  assign issue_last = (cnt_r == n_r - CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == FUNC_QUERY)
          state_nxt = (n_eff == '0) ? ST_HOLD : ST_ISSUE;
      end
      ST_ISSUE: if (issue_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (fin_v && fin_last) state_nxt = ST_HOLD;
      ST_HOLD:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the FSM
  always_comb begin
    in_tready = 1'b0;
    issue_v   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_ISSUE: issue_v = 1'b1;
      ST_DRAIN: ;
      ST_HOLD:  out_load = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) cnt_r <= '0;
      else if (issue_v) cnt_r <= cnt_r + CW'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == FUNC_QUERY) begin
      n_r  <= n_eff;
      qx_r <= in_x;
      qy_r <= in_y;
    end
    if (out_load) out_data_r <= best_r;
    best_r <= best_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- datapath front: read, diff, square ----------------
  logic v0_r, l0_r, v1_r, l1_r, v2_r, l2_r;
  logic [COORD_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0] sqx_r, sqy_r;
  pk_t pk1_r, pk2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= issue_v;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    l0_r  <= issue_last;
    l1_r  <= l0_r;
    l2_r  <= l1_r;
    dx_r  <= (qx_r >= rd_ent_r.cx) ? qx_r - rd_ent_r.cx : rd_ent_r.cx - qx_r;
    dy_r  <= (qy_r >= rd_ent_r.cy) ? qy_r - rd_ent_r.cy : rd_ent_r.cy - qy_r;
    pk1_r <= '{top: rd_ent_r.top, r1: rd_ent_r.r1, h1: rd_ent_r.h1, r2: rd_ent_r.r2};
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
    pk2_r <= pk1_r;
  end

  // ---------------- floor square root, one root bit per stage ----------------
  sq_t sq_r   [0:SQ_STEPS];
  sq_t sq_nxt [1:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_r[0].vld <= 1'b0;
    else sq_r[0].vld <= v2_r;
    sq_r[0].last <= l2_r;
    sq_r[0].rad  <= RAD_W'({1'b0, sqx_r} + {1'b0, sqy_r});
    sq_r[0].rem  <= '0;
    sq_r[0].root <= '0;
    sq_r[0].pk   <= pk2_r;
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    logic [REM_W-1:0] cur, trial;
    always_comb begin
      cur   = {sq_r[j].rem[REM_W-3:0], sq_r[j].rad[RAD_W-1 -: 2]};
      trial = {1'b0, sq_r[j].root, 2'b01};
      sq_nxt[j+1]      = sq_r[j];
      sq_nxt[j+1].rad  = {sq_r[j].rad[RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
        sq_nxt[j+1].rem  = cur - trial;
        sq_nxt[j+1].root = {sq_r[j].root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_nxt[j+1].rem  = cur;
        sq_nxt[j+1].root = {sq_r[j].root[ROOT_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_r[j+1].vld <= 1'b0;
      else sq_r[j+1].vld <= sq_nxt[j+1].vld;
      sq_r[j+1].last <= sq_nxt[j+1].last;
      sq_r[j+1].rad  <= sq_nxt[j+1].rad;
      sq_r[j+1].rem  <= sq_nxt[j+1].rem;
      sq_r[j+1].root <= sq_nxt[j+1].root;
      sq_r[j+1].pk   <= sq_nxt[j+1].pk;
    end
  end

  // ---------------- classify against the radii ----------------
  sq_t sqo;
  cls_t cls_nxt, cls_r;
  logic [ROOT_W-1:0] d;
  assign sqo = sq_r[SQ_STEPS];
  assign d   = sqo.root;

  always_comb begin
    cls_nxt.vld  = sqo.vld;
    cls_nxt.last = sqo.last;
    cls_nxt.h1   = sqo.pk.h1;
    cls_nxt.seg  = SEG_NONE;
    cls_nxt.a    = '0;
    cls_nxt.b    = '0;
    cls_nxt.den  = '1;
    if (d >= ROOT_W'(sqo.pk.r2)) begin
      cls_nxt.seg = SEG_NONE;
    end else if (d < ROOT_W'(sqo.pk.r1)) begin
      // inner cone: step scaled by run / r1
      cls_nxt.a   = sqo.pk.r1 - d[COORD_W-1:0];
      cls_nxt.den = sqo.pk.r1;
      if (sqo.pk.top >= sqo.pk.h1) begin
        cls_nxt.seg = SEG_UP;
        cls_nxt.b   = sqo.pk.top - sqo.pk.h1;
      end else begin
        cls_nxt.seg = SEG_DOWN;
        cls_nxt.b   = sqo.pk.h1 - sqo.pk.top;
      end
    end else begin
      cls_nxt.seg = SEG_OUTER;
      cls_nxt.a   = sqo.pk.r2 - d[COORD_W-1:0];
      cls_nxt.b   = sqo.pk.h1;
      cls_nxt.den = sqo.pk.r2 - sqo.pk.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cls_r.vld <= 1'b0;
    else cls_r.vld <= cls_nxt.vld;
    cls_r.last <= cls_nxt.last;
    cls_r.seg  <= cls_nxt.seg;
    cls_r.a    <= cls_nxt.a;
    cls_r.b    <= cls_nxt.b;
    cls_r.den  <= cls_nxt.den;
    cls_r.h1   <= cls_nxt.h1;
  end

  // ---------------- multiply, then restoring divide ----------------
  dv_t dv_r   [0:DIV_STEPS];
  dv_t dv_nxt [1:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0].vld <= 1'b0;
    else dv_r[0].vld <= cls_r.vld;
    dv_r[0].last <= cls_r.last;
    dv_r[0].seg  <= cls_r.seg;
    dv_r[0].dvd  <= cls_r.a * cls_r.b;
    dv_r[0].rem  <= '0;
    dv_r[0].quo  <= '0;
    dv_r[0].den  <= cls_r.den;
    dv_r[0].h1   <= cls_r.h1;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [COORD_W:0] cur;
    always_comb begin
      cur = {dv_r[k].rem, dv_r[k].dvd[NUM_W-1]};
      dv_nxt[k+1]     = dv_r[k];
      dv_nxt[k+1].dvd = {dv_r[k].dvd[NUM_W-2:0], 1'b0};
      if (cur >= {1'b0, dv_r[k].den}) begin
        dv_nxt[k+1].rem = COORD_W'(cur - {1'b0, dv_r[k].den});
        dv_nxt[k+1].quo = {dv_r[k].quo[HGT_W-2:0], 1'b1};
      end else begin
        dv_nxt[k+1].rem = cur[COORD_W-1:0];
        dv_nxt[k+1].quo = {dv_r[k].quo[HGT_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1].vld <= 1'b0;
      else dv_r[k+1].vld <= dv_nxt[k+1].vld;
      dv_r[k+1].last <= dv_nxt[k+1].last;
      dv_r[k+1].seg  <= dv_nxt[k+1].seg;
      dv_r[k+1].dvd  <= dv_nxt[k+1].dvd;
      dv_r[k+1].rem  <= dv_nxt[k+1].rem;
      dv_r[k+1].quo  <= dv_nxt[k+1].quo;
      dv_r[k+1].den  <= dv_nxt[k+1].den;
      dv_r[k+1].h1   <= dv_nxt[k+1].h1;
    end
  end

  // ---------------- peak value and running max ----------------
  dv_t fin;
  logic [HGT_W-1:0] pv;
  assign fin      = dv_r[DIV_STEPS];
  assign fin_v    = fin.vld;
  assign fin_last = fin.last;

  always_comb begin
    case (fin.seg)
      SEG_UP:    pv = fin.h1 + fin.quo;
      SEG_DOWN:  pv = fin.h1 - fin.quo;
      SEG_OUTER: pv = fin.quo;
      default:   pv = '0;
    endcase
  end

  always_comb begin
    best_nxt = best_r;
    if (state_r == ST_IDLE) best_nxt = '0;
    else if (fin_v && pv > best_r) best_nxt = pv;
  end

endmodule

@@ tb/tb_cone_peak_landscape_eval.sv @@
// Self-checking testbench for cone_peak_landscape_eval: peak table writes,
// landscape queries, peak_count settings, random idling and back-pressure.
// Depends on cple_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_cone_peak_landscape_eval;
  import cple_pkg::*;

  localparam int N_PEAKS = 64;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [135:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [15:0]  out_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [6:0]   cfg_wr_data = '0;

  always #5 clk = ~clk;

  cone_peak_landscape_eval u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Shadow copy of the peak table and the count register.
  peak_entry_t peak_tbl [N_PEAKS];
  logic [6:0]  active_peaks;

  logic [15:0] fitness_q[$];
  int          n_errors;
  int          hold_off;    // receiver long-stall request, in cycles
  bit          fast_mode;   // no idling stretch

  // Value of one peak at a query point; 64-bit arithmetic throughout.
  function automatic longint unsigned cone_value(peak_entry_t p,
                                                 longint unsigned x,
                                                 longint unsigned y);
    longint unsigned dx, dy, sq, d, rem, bitv, run;
    dx = (x >= p.cx) ? x - p.cx : p.cx - x;
    dy = (y >= p.cy) ? y - p.cy : p.cy - y;
    sq = dx * dx + dy * dy;
    // bitwise floor root
    d = 0; rem = sq; bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= d + bitv) begin
        rem -= d + bitv;
        d = (d >> 1) + bitv;
      end else begin
        d >>= 1;
      end
      bitv >>= 2;
    end
    if (d >= p.r2) return 0;
    if (d < p.r1) begin
      run = p.r1 - d;
      if (p.top >= p.h1) return p.h1 + (run * (p.top - p.h1)) / p.r1;
      return p.h1 - (run * (p.h1 - p.top)) / p.r1;
    end
    return (p.h1 * (p.r2 - d)) / (p.r2 - p.r1);
  endfunction

  function automatic logic [15:0] landscape_max(logic [23:0] x, logic [23:0] y);
    longint unsigned best, v;
    int n;
    best = 0;
    n = (active_peaks > N_PEAKS) ? N_PEAKS : active_peaks;
    for (int i = 0; i < n; i++) begin
      v = cone_value(peak_tbl[i], x, y);
      if (v > best) best = v;
    end
    if (best > 65535) best = 65535;
    return best[15:0];
  endfunction

  function automatic int idle_len();
    if (fast_mode) return 0;
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one transaction; predicts at acceptance. tvalid stays high after
  // acceptance so a following transaction can go out back to back.
  task automatic send_item(logic func, logic [5:0] slot, logic [23:0] px,
                           logic [23:0] py, logic [15:0] top, logic [23:0] r1,
                           logic [15:0] h1, logic [23:0] r2);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {2'b00, r2, h1, r1, top, py, px, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (func == FUNC_WRITE) begin
      peak_tbl[slot] = '{cx: px, cy: py, top: top, r1: r1, h1: h1, r2: r2};
    end else begin
      fitness_q = {fitness_q, landscape_max(px, py)};
    end
  endtask

  // Drop tvalid before any wait that is not a send.
  task automatic release_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_peak(logic [5:0] s, logic [23:0] cx, logic [23:0] cy,
                            logic [15:0] top, logic [23:0] r1, logic [15:0] h1,
                            logic [23:0] r2);
    send_item(FUNC_WRITE, s, cx, cy, top, r1, h1, r2);
  endtask

  task automatic query(logic [23:0] x, logic [23:0] y);
    send_item(FUNC_QUERY, 6'($urandom), x, y, 16'($urandom), 24'($urandom),
              16'($urandom), 24'($urandom));
  endtask

  // Idle the block, then write peak_count.
  task automatic set_peak_count(logic [6:0] n);
    release_input();
    while (fitness_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_peaks = n;
  endtask

  // Random peak with mostly modest radii so points land on slopes.
  task automatic random_peak(logic [5:0] s);
    logic [23:0] r1, r2;
    case ($urandom_range(0, 4))
      0: begin r1 = 24'($urandom); r2 = 24'($urandom); end
      1: begin r1 = 0; r2 = 24'($urandom_range(0, 4000)); end
      2: begin r1 = 24'($urandom_range(0, 3000)); r2 = r1; end
      default: begin
        r1 = 24'($urandom_range(0, 2000));
        r2 = 24'(r1 + $urandom_range(1, 3000));
      end
    endcase
    write_peak(s, 24'($urandom_range(0, 8000)), 24'($urandom_range(0, 8000)),
               16'($urandom), r1, 16'($urandom), r2);
  endtask

  task automatic random_query();
    if ($urandom_range(0, 9) == 0) query(24'($urandom), 24'($urandom));
    else query(24'($urandom_range(0, 8000)), 24'($urandom_range(0, 8000)));
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (fitness_q.size() == 0) begin
          $error("fitness: unexpected transaction, actual %0d", out_tdata);
          n_errors++;
        end else begin
          if (out_tdata !== fitness_q[0]) begin
            $error("fitness: expected %0d actual %0d", fitness_q[0], out_tdata);
            n_errors++;
          end
          void'(fitness_q.pop_front());
        end
      end
    end
  end

  // Receiver idling.
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        hold_off--;
      end else if (!fast_mode && $urandom_range(0, 99) < 25) begin
        stall = idle_len();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Extremes of every field, inner-cone rising and falling, degenerate radii.
  task automatic test_directed();
    set_peak_count(7'd0);
    query(24'hFFFFFF, 24'h0);          // no peaks: zero
    write_peak(6'd0, 24'd1000, 24'd1000, 16'hFFFF, 24'd500, 16'h8000, 24'd900);
    write_peak(6'd1, 24'd2000, 24'd2000, 16'h0100, 24'd400, 16'hF000, 24'd800);
    write_peak(6'd2, 24'd0, 24'd0, 16'hFFFF, 24'd0, 16'h0, 24'd0);
    write_peak(6'd3, 24'hFFFFFF, 24'hFFFFFF, 16'h1234, 24'hFFFFFF, 16'hFFFF,
               24'd100);
    write_peak(6'd63, 24'h800000, 24'h7FFFFF, 16'h0, 24'd10, 16'h0,
               24'hFFFFFF);
    for (int i = 4; i < 63; i++) random_peak(6'(i));
    set_peak_count(7'd5);
    query(24'd1000, 24'd1000);         // peak centre
    query(24'd1300, 24'd1000);         // inner cone falling
    query(24'd1700, 24'd1000);         // outer ring
    query(24'd2100, 24'd2050);         // inner cone rising
    query(24'd0, 24'd0);
    query(24'hFFFFFF, 24'hFFFFFF);
    query(24'hFFFFF0, 24'hFFFFFF);
    set_peak_count(7'd64);
    query(24'h800000, 24'h7FFFFF);
    query(24'h0, 24'hFFFFFF);
    set_peak_count(7'd127);            // clamps to table size
    query(24'd1000, 24'd1000);
    query(24'h800100, 24'h7FFFFF);
  endtask

  task automatic test_random(int n_items);
    for (int i = 0; i < n_items; i++) begin
      fast_mode = ($urandom_range(0, 199) == 0) ? ~fast_mode : fast_mode;
      if ($urandom_range(0, 3) == 0) random_peak(6'($urandom_range(0, 63)));
      else random_query();
    end
  endtask

  // Receiver stalls long while queries keep coming; then sender drains.
  task automatic test_backpressure();
    hold_off = 1500;
    for (int i = 0; i < 12; i++) random_query();
    release_input();
    while (fitness_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) random_query();
  endtask

  initial begin
    n_errors = 0;
    hold_off = 0;
    fast_mode = 0;
    active_peaks = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    set_peak_count(7'd16);
    test_random(500);
    set_peak_count(7'd1);
    test_random(400);
    set_peak_count(7'd64);
    test_random(500);
    test_backpressure();
    set_peak_count(7'd100);
    test_random(300);
    set_peak_count(7'd0);
    test_random(150);
    release_input();
    while (fitness_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/cple_pkg.sv
hw/rtl/cone_peak_landscape_eval.sv
tb/tb_cone_peak_landscape_eval.sv
